// File: src/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SEXTET_W   = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned REPORT_W   = 16;
  localparam int unsigned CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_DATA,
    KIND_TERM
  } kind_e;

  // Classified character as it travels from front to back.
  typedef struct packed {
    kind_e                kind;
    logic [SEXTET_W-1:0]  sextet;
  } cls_t;

endpackage

// File: src/b64d_front.sv
// Front end: classifies each character against the MIME base64 alphabet.
module b64d_front (
  input  logic [b64d_pkg::CHAR_W-1:0] char_in_i,
  output b64d_pkg::cls_t              cls_o
);
  import b64d_pkg::*;

  logic [CHAR_W-1:0] ch;

  always_comb begin
    ch           = char_in_i;
    cls_o.kind   = KIND_SKIP;
    cls_o.sextet = '0;
    if (ch == 8'h00) begin
      cls_o.kind = KIND_TERM;
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      cls_o.kind   = KIND_DATA;
      cls_o.sextet = SEXTET_W'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      cls_o.kind   = KIND_DATA;
      cls_o.sextet = SEXTET_W'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      cls_o.kind   = KIND_DATA;
      cls_o.sextet = SEXTET_W'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2b) begin
      cls_o.kind   = KIND_DATA;
      cls_o.sextet = 6'd62;
    end else if (ch == 8'h2f) begin
      cls_o.kind   = KIND_DATA;
      cls_o.sextet = 6'd63;
    end
  end

endmodule

// File: src/b64d_queue.sv
// Two-entry queue that decouples the classifier from the decode back end.
module b64d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::cls_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64d_pkg::cls_t head_data_o
);
  import b64d_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o       = (fill_q == 2'd2);
  assign head_valid_o = (fill_q != 2'd0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/b64d_back.sv
// Back end: group phase, byte assembly, byte limit and the result register.
module b64d_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [b64d_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                           head_valid_i,
  input  b64d_pkg::cls_t                 head_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           byte_valid_o,
  output logic [b64d_pkg::BYTE_W-1:0]    data_byte_o,
  output logic [b64d_pkg::REPORT_W-1:0]  byte_count_o,
  output logic                           text_done_o
);
  import b64d_pkg::*;

  logic [LIMIT_W-1:0]    limit_q;
  logic [1:0]            phase_q, phase_d;
  logic [SEXTET_W-1:0]   prev_q, prev_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic                  out_valid_q;
  logic                  byte_valid_q, byte_valid_d;
  logic [BYTE_W-1:0]     data_byte_q, data_byte_d;
  logic [REPORT_W-1:0]   byte_count_q, byte_count_d;
  logic                  text_done_q, text_done_d;

  logic                  makes;
  logic                  room;
  logic [BYTE_W-1:0]     assembled;
  logic [SEXTET_W-1:0]   cur;

  // Advance when the result register is empty or being drained.
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);
  assign cur   = head_data_i.sextet;
  assign room  = (CMP_W'(count_q) < CMP_W'(limit_q)) && (count_q != '1);

  always_comb begin
    makes     = 1'b1;
    assembled = '0;
    unique case (phase_q)
      2'd0: makes = 1'b0;
      2'd1: assembled = {prev_q, cur[5:4]};
      2'd2: assembled = {prev_q[3:0], cur[5:2]};
      2'd3: assembled = {prev_q[1:0], cur};
      default: makes = 1'b0;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    count_d      = count_q;
    byte_valid_d = 1'b0;
    data_byte_d  = '0;
    text_done_d  = 1'b0;
    byte_count_d = REPORT_W'(count_q);
    unique case (head_data_i.kind)
      KIND_TERM: begin
        phase_d     = '0;
        prev_d      = '0;
        count_d     = '0;
        text_done_d = 1'b1;
      end
      KIND_DATA: begin
        phase_d = phase_q + 2'd1;
        prev_d  = cur;
        if (makes && room) begin
          byte_valid_d = 1'b1;
          data_byte_d  = assembled;
          count_d      = count_q + COUNT_BITS'(1);
          byte_count_d = REPORT_W'(count_q + COUNT_BITS'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      phase_q     <= '0;
      prev_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        phase_q     <= phase_d;
        prev_q      <= prev_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_valid_q <= byte_valid_d;
      data_byte_q  <= data_byte_d;
      byte_count_q <= byte_count_d;
      text_done_q  <= text_done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = byte_valid_q;
  assign data_byte_o  = data_byte_q;
  assign byte_count_o = byte_count_q;
  assign text_done_o  = text_done_q;

endmodule

// File: src/base64_stream_decoder_unit.sv
// Top level of the MIME base64 stream decoder.
// Takes one character per item and returns one result per item: an optional
// decoded byte, the running byte count of the current text, and a flag on the
// zero terminator. Characters outside the MIME alphabet (including '=') are
// skipped. Throughput is one item per clock cycle while neither side stalls;
// the classifier writes each item into a two-entry queue and the back end
// retires one item a cycle into the result register unless the result side
// stalls. An item passes the queue and then the result register before its
// result is offered. in_stall_o rises only when the queue is full while the
// result side stalls. The user must write max_bytes through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block does not enforce it.
module base64_stream_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [b64d_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [b64d_pkg::CHAR_W-1:0]    char_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           byte_valid_o,
  output logic [b64d_pkg::BYTE_W-1:0]    data_byte_o,
  output logic [b64d_pkg::REPORT_W-1:0]  byte_count_o,
  output logic                           text_done_o
);
  import b64d_pkg::*;

  cls_t cls;
  cls_t head_data;
  logic full;
  logic pop;
  logic head_valid;

  assign in_stall_o = full;

  b64d_front u_front (
    .char_in_i (char_in_i),
    .cls_o     (cls)
  );

  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (cls),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_valid_o (byte_valid_o),
    .data_byte_o  (data_byte_o),
    .byte_count_o (byte_count_o),
    .text_done_o  (text_done_o)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the base64 stream decoder: directed table, then random texts.
`timescale 1ns / 1ps

module tb_top;
  import b64d_pkg::*;

  typedef struct packed {
    logic                byte_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic [REPORT_W-1:0] byte_count;
    logic                text_done;
  } decode_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              pinned;
    decode_result_t    want;
  } dir_row_t;

  localparam logic PIN  = 1'b1;
  localparam logic CALC = 1'b0;
  localparam decode_result_t NO_RES = '0;

  localparam int NUM_DIR      = 25;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_PAD    = 4;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{8'h00, PIN,  '{1'b0, 8'h00, 16'd0, 1'b1}},
    '{"T",   PIN,  '{1'b0, 8'h00, 16'd0, 1'b0}},
    '{"W",   PIN,  '{1'b1, 8'h4d, 16'd1, 1'b0}},
    '{"F",   PIN,  '{1'b1, 8'h61, 16'd2, 1'b0}},
    '{"u",   PIN,  '{1'b1, 8'h6e, 16'd3, 1'b0}},
    '{"=",   PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{8'hff, PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{8'h80, PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{8'h7f, PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{"@",   PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{"+",   PIN,  '{1'b0, 8'h00, 16'd3, 1'b0}},
    '{"/",   CALC, NO_RES},
    '{"A",   CALC, NO_RES},
    '{"z",   CALC, NO_RES},
    '{"a",   CALC, NO_RES},
    '{"Z",   CALC, NO_RES},
    '{"0",   CALC, NO_RES},
    '{"9",   CALC, NO_RES},
    '{"=",   CALC, NO_RES},
    '{8'h00, CALC, NO_RES},
    '{"/",   PIN,  '{1'b0, 8'h00, 16'd0, 1'b0}},
    '{"/",   PIN,  '{1'b1, 8'hff, 16'd1, 1'b0}},
    '{"A",   CALC, NO_RES},
    '{"A",   CALC, NO_RES},
    '{8'h00, PIN,  '{1'b0, 8'h00, 16'd3, 1'b1}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CHAR_W-1:0]   char_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                byte_valid;
  logic [BYTE_W-1:0]   data_byte;
  logic [REPORT_W-1:0] byte_count;
  logic                text_done;

  // Decoder state mirrored by the bench
  logic [1:0]            grp_phase;
  logic [SEXTET_W-1:0]   last_sextet;
  logic [COUNT_BITS-1:0] byte_total;
  logic [LIMIT_W-1:0]    byte_limit;

  decode_result_t pending_results [$];
  decode_result_t got_res;
  decode_result_t want_res;
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             stall_left = 0;
  int             stall_draw;
  logic           no_idle = 1'b0;

  base64_stream_decoder_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_in_i    (char_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .byte_valid_o (byte_valid),
    .data_byte_o  (data_byte),
    .byte_count_o (byte_count),
    .text_done_o  (text_done)
  );

  always #10 clk = ~clk;

  function automatic int sextet_of(input logic [CHAR_W-1:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic decode_result_t decode_char(input logic [CHAR_W-1:0] c);
    decode_result_t      r;
    int                  s;
    logic [SEXTET_W-1:0] cur;
    logic [BYTE_W-1:0]   b;
    logic                makes;
    r = '0;
    if (c == '0) begin
      r.text_done  = 1'b1;
      r.byte_count = REPORT_W'(byte_total);
      grp_phase    = '0;
      last_sextet  = '0;
      byte_total   = '0;
    end else begin
      s = sextet_of(c);
      if (s >= 0) begin
        cur   = s[SEXTET_W-1:0];
        makes = 1'b1;
        case (grp_phase)
          2'd0: begin
            makes = 1'b0;
            b = '0;
          end
          2'd1: b = {last_sextet, cur[5:4]};
          2'd2: b = {last_sextet[3:0], cur[5:2]};
          default: b = {last_sextet[1:0], cur};
        endcase
        // Drop the byte once the limit or the counter ceiling is reached
        if (makes && CMP_W'(byte_total) < CMP_W'(byte_limit) && byte_total != '1) begin
          r.byte_valid = 1'b1;
          r.data_byte  = b;
          byte_total   = byte_total + 1'b1;
        end
        grp_phase   = grp_phase + 2'd1;
        last_sextet = cur;
      end
      r.byte_count = REPORT_W'(byte_total);
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_alpha();
    int i;
    i = $urandom_range(0, 63);
    if (i < 26) return CHAR_W'(int'("A") + i);
    if (i < 52) return CHAR_W'(int'("a") + i - 26);
    if (i < 62) return CHAR_W'(int'("0") + i - 52);
    if (i == 62) return "+";
    return "/";
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic pinned,
                           input decode_result_t want);
    int             gap;
    decode_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    pred = decode_char(c);
    pending_results.insert(pending_results.size(), pinned ? want : pred);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    byte_limit = v;
  endtask

  task automatic send_text(input int len);
    int                pick;
    logic [CHAR_W-1:0] c;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) c = rand_alpha();
      else if (pick < 92) c = "=";
      else c = CHAR_W'($urandom_range(0, 255));
      send_char(c, CALC, NO_RES);
    end
    send_char('0, CALC, NO_RES);
  endtask

  // Result side: after each taken item, draw a random stall length, zero in no-idle phases
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (out_valid && !out_stall) begin
        stall_draw = no_idle ? 0 : $urandom_range(0, 5);
        out_stall  <= (stall_draw != 0);
        stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = {byte_valid, data_byte, byte_count, text_done};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected item: valid=%0b byte=%02h count=%0d done=%0b",
                   $realtime, got_res.byte_valid, got_res.data_byte,
                   got_res.byte_count, got_res.text_done);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.byte_valid !== want_res.byte_valid ||
            got_res.data_byte  !== want_res.data_byte ||
            got_res.byte_count !== want_res.byte_count ||
            got_res.text_done  !== want_res.text_done) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: exp valid=%0b byte=%02h count=%0d done=%0b,",
                     $realtime, want_res.byte_valid, want_res.data_byte,
                     want_res.byte_count, want_res.text_done,
                     " got valid=%0b byte=%02h count=%0d done=%0b",
                     got_res.byte_valid, got_res.data_byte,
                     got_res.byte_count, got_res.text_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int                len;
    int                sent;
    logic [LIMIT_W-1:0] lim;
    grp_phase   = '0;
    last_sextet = '0;
    byte_total  = '0;
    byte_limit  = LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++)
      send_char(DIR_ROWS[i].ch, DIR_ROWS[i].pinned, DIR_ROWS[i].want);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 6)
        0: lim = '0;
        1: lim = LIMIT_W'(1);
        2: lim = LIMIT_W'($urandom_range(2, 40));
        3: lim = '1;
        4: lim = LIMIT_W'($urandom_range(0, 65535));
        default: lim = LIMIT_W'($urandom_range(41, 200));
      endcase
      set_limit(lim);
      no_idle = (p % 4 == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short texts, now and then a long one to pass the limit
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
        send_text(len);
        sent += len + 1;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD * 2) @(posedge clk);
    if (pending_results.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: base64_stream_decoder_unit.f
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_stream_decoder_unit.sv
bench/tb_top.sv
